@@ src/imusa_pkg.sv @@
`timescale 1ns / 1ps
package imusa_pkg;

	localparam int SAMPLE_BITS = 32;
	localparam int TIME_BITS   = 48;
	localparam int NUM_W       = 82;
	localparam int DEN_W       = 48;

	localparam logic [1:0] SENS_ACC  = 2'd0;
	localparam logic [1:0] SENS_GYRO = 2'd1;
	localparam logic [1:0] SENS_MAG  = 2'd2;

	typedef logic signed [SAMPLE_BITS-1:0] smp_t;
	typedef smp_t [2:0] vec_t;
	typedef logic [TIME_BITS-1:0] tim_t;

	typedef struct packed {
		logic [1:0] sensor_type;
		smp_t       sample_x;
		smp_t       sample_y;
		smp_t       sample_z;
		tim_t       timestamp;
	} sample_t;

	typedef struct packed {
		smp_t acc_unit_x;
		smp_t acc_unit_y;
		smp_t acc_unit_z;
		smp_t mag_interp_x;
		smp_t mag_interp_y;
		smp_t mag_interp_z;
		smp_t rate_x;
		smp_t rate_y;
		smp_t rate_z;
		tim_t align_time;
	} result_t;

	typedef struct packed {
		vec_t acc_prev;
		vec_t acc_next;
		vec_t mag_prev;
		vec_t mag_next;
		vec_t gyro;
		tim_t acc_prev_time;
		tim_t acc_next_time;
		tim_t mag_prev_time;
		tim_t mag_next_time;
		tim_t gyro_time;
	} job_t;

	typedef struct packed {
		logic             start;
		logic [NUM_W-1:0] num;
		logic [DEN_W-1:0] den;
	} div_req_t;

	typedef struct packed {
		logic             done;
		logic [NUM_W-1:0] quo;
	} div_rsp_t;

	typedef enum logic [3:0] {
		B_IDLE,
		B_SETUP,
		B_MUL,
		B_IDIV,
		B_SQ,
		B_SQRT,
		B_NSET,
		B_NDIV,
		B_DONE
	} back_state_t;

	function automatic logic [SAMPLE_BITS-1:0] umag(smp_t v);
		return v[SAMPLE_BITS-1] ? SAMPLE_BITS'(-v) : SAMPLE_BITS'(v);
	endfunction

endpackage

@@ src/imusa_front.sv @@
`timescale 1ns / 1ps
module imusa_front (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                sample_valid,
	output logic                sample_ready,
	input  imusa_pkg::sample_t  sample,
	input  logic                full,
	output logic                push,
	output imusa_pkg::job_t     job
);

	imusa_pkg::job_t slot_q, n;
	logic gyro_held_q, acc_held_q, mag_held_q;
	logic ng, na, nm, align, accept;
	imusa_pkg::vec_t v;

	assign sample_ready = !full;
	assign accept = sample_valid && sample_ready;

	always_comb begin
		v[0] = sample.sample_x;
		v[1] = sample.sample_y;
		v[2] = sample.sample_z;
		n  = slot_q;
		ng = gyro_held_q;
		na = acc_held_q;
		nm = mag_held_q;
		if (!ng) begin
			unique case (sample.sensor_type)
				imusa_pkg::SENS_ACC: begin
					n.acc_prev = v;
					n.acc_prev_time = sample.timestamp;
				end
				imusa_pkg::SENS_MAG: begin
					n.mag_prev = v;
					n.mag_prev_time = sample.timestamp;
				end
				default: begin
					n.gyro = v;
					n.gyro_time = sample.timestamp;
					ng = 1'b1;
				end
			endcase
		end else begin
			unique case (sample.sensor_type)
				imusa_pkg::SENS_ACC: begin
					n.acc_next = v;
					n.acc_next_time = sample.timestamp;
					na = 1'b1;
				end
				imusa_pkg::SENS_MAG: begin
					n.mag_next = v;
					n.mag_next_time = sample.timestamp;
					nm = 1'b1;
				end
				default: begin
					n.gyro = v;
					n.gyro_time = sample.timestamp;
					if (na) begin
						n.acc_prev = n.acc_next;
						n.acc_prev_time = n.acc_next_time;
					end
					if (nm) begin
						n.mag_prev = n.mag_next;
						n.mag_prev_time = n.mag_next_time;
					end
					na = 1'b0;
					nm = 1'b0;
				end
			endcase
		end
		align = na && nm;
		job = n;
		if (align) begin
			n.acc_prev = n.acc_next;
			n.acc_prev_time = n.acc_next_time;
			n.mag_prev = n.mag_next;
			n.mag_prev_time = n.mag_next_time;
			ng = 1'b0;
			na = 1'b0;
			nm = 1'b0;
		end
	end

	assign push = accept && align;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slot_q      <= '0;
			gyro_held_q <= 1'b0;
			acc_held_q  <= 1'b0;
			mag_held_q  <= 1'b0;
		end else if (accept) begin
			slot_q      <= n;
			gyro_held_q <= ng;
			acc_held_q  <= na;
			mag_held_q  <= nm;
		end
	end

endmodule

@@ src/imusa_fifo.sv @@
`timescale 1ns / 1ps
module imusa_fifo #(
	parameter int DEPTH = 2
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	input  imusa_pkg::job_t wdata,
	input  logic            pop,
	output imusa_pkg::job_t rdata,
	output logic            full,
	output logic            empty
);

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	imusa_pkg::job_t mem_q [DEPTH];
	logic [AW-1:0] wr_q, rd_q;
	logic [CW-1:0] cnt_q;

	assign full  = cnt_q == CW'(DEPTH);
	assign empty = cnt_q == '0;
	assign rdata = mem_q[rd_q];

	always_ff @(posedge clk) begin
		if (push) mem_q[wr_q] <= wdata;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) wr_q <= (wr_q == AW'(DEPTH - 1)) ? '0 : wr_q + 1'b1;
			if (pop) rd_q <= (rd_q == AW'(DEPTH - 1)) ? '0 : rd_q + 1'b1;
			if (push && !pop) cnt_q <= cnt_q + 1'b1;
			else if (pop && !push) cnt_q <= cnt_q - 1'b1;
		end
	end

endmodule

@@ src/imusa_div.sv @@
`timescale 1ns / 1ps
module imusa_div (
	input  logic                clk,
	input  logic                arst_n,
	input  imusa_pkg::div_req_t req,
	output imusa_pkg::div_rsp_t rsp
);

	localparam int NW = imusa_pkg::NUM_W;
	localparam int DW = imusa_pkg::DEN_W;
	localparam int CW = $clog2(NW);

	logic busy_q, done_q;
	logic [CW-1:0] cnt_q;
	logic [NW-1:0] nq_q;
	logic [DW-1:0] r_q, den_q;
	logic [DW:0] rs, rn;
	logic ge;

	always_comb begin
		rs = {r_q, nq_q[NW-1]};
		ge = rs >= {1'b0, den_q};
		rn = ge ? rs - {1'b0, den_q} : rs;
	end

	// round half away from zero on the magnitude
	assign rsp.done = done_q;
	assign rsp.quo  = nq_q + NW'({r_q, 1'b0} >= {1'b0, den_q});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CW'(NW - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			nq_q  <= req.num;
			r_q   <= '0;
			den_q <= req.den;
		end else if (busy_q) begin
			nq_q <= {nq_q[NW-2:0], ge};
			r_q  <= rn[DW-1:0];
		end
	end

endmodule

@@ src/imusa_back.sv @@
`timescale 1ns / 1ps
module imusa_back (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 empty,
	input  imusa_pkg::job_t      job,
	output logic                 pop,
	output imusa_pkg::div_req_t  dreq,
	input  imusa_pkg::div_rsp_t  drsp,
	output logic                 result_valid,
	input  logic                 result_ready,
	output imusa_pkg::result_t   result
);

	localparam int SW = imusa_pkg::SAMPLE_BITS;
	localparam int TW = imusa_pkg::TIME_BITS;
	localparam int NW = imusa_pkg::NUM_W;
	localparam int DW = imusa_pkg::DEN_W;

	imusa_pkg::back_state_t st_q, st_d;
	imusa_pkg::job_t job_q;
	logic dstart_q;
	logic [NW-1:0] dnum_q;
	logic [DW-1:0] dden_q;
	imusa_pkg::result_t out_q;
	logic out_valid_q;

	logic [2:0] k_q;
	logic [5:0] mcnt_q;
	logic [1:0] sc_q, c_q;
	logic [4:0] qcnt_q;
	imusa_pkg::smp_t ires_q [6];
	imusa_pkg::smp_t unit_q [3];
	imusa_pkg::smp_t y1_q;
	logic neg_q;
	logic [TW-1:0] span_q, el_q;
	logic [NW-1:0] mc_q, acc_q;
	logic [2*SW-1:0] sum_q, prod_q, sqx_q, nsum;
	logic [SW-1:0] root_q;
	logic [SW+1:0] rem_q;

	// interpolation operand select
	logic is_mag;
	logic [1:0] idx;
	imusa_pkg::smp_t y1, y2;
	imusa_pkg::tim_t t1, t2, t3, span, el;
	logic signed [SW:0] dy;
	logic [SW:0] my;
	logic neg, skip;
	logic sat;
	logic signed [SW+2:0] res;
	imusa_pkg::smp_t ires_new;
	logic [SW-1:0] sqm;
	logic [SW+3:0] remx, trial;
	logic sq_ge;
	logic [SW-1:0] nm;
	logic [30:0] um;
	imusa_pkg::smp_t unit_new;
	logic out_free;

	always_comb begin
		is_mag = k_q >= 3'd3;
		idx = is_mag ? 2'(k_q - 3'd3) : k_q[1:0];
		y1 = is_mag ? job_q.mag_prev[idx] : job_q.acc_prev[idx];
		y2 = is_mag ? job_q.mag_next[idx] : job_q.acc_next[idx];
		t1 = is_mag ? job_q.mag_prev_time : job_q.acc_prev_time;
		t2 = is_mag ? job_q.mag_next_time : job_q.acc_next_time;
		t3 = job_q.gyro_time;
		dy = {y2[SW-1], y2} - {y1[SW-1], y1};
		my = dy[SW] ? (SW+1)'(-dy) : (SW+1)'(dy);
		neg = dy[SW];
		if (t2 > t1) span = t2 - t1;
		else begin
			span = t1 - t2;
			neg = !neg;
		end
		if (t3 > t1) el = t3 - t1;
		else begin
			el = t1 - t3;
			neg = !neg;
		end
		skip = (t1 == t2) || (my == '0) || (t3 == t1);

		sat = (|drsp.quo[NW-1:SW+1]) || (drsp.quo[SW] && (|drsp.quo[SW-1:0]));
		res = neg_q ? {{3{y1_q[SW-1]}}, y1_q} - {2'b00, drsp.quo[SW:0]}
			: {{3{y1_q[SW-1]}}, y1_q} + {2'b00, drsp.quo[SW:0]};
		if (sat) ires_new = neg_q ? {1'b1, {(SW-1){1'b0}}} : {1'b0, {(SW-1){1'b1}}};
		else if (res > (SW+3)'($signed({1'b0, {(SW-1){1'b1}}})))
			ires_new = {1'b0, {(SW-1){1'b1}}};
		else if (res < -(SW+3)'($signed({1'b0, 1'b1, {(SW-1){1'b0}}})))
			ires_new = {1'b1, {(SW-1){1'b0}}};
		else ires_new = res[SW-1:0];

		sqm = (sc_q == 2'd3) ? '0 : imusa_pkg::umag(ires_q[3'(sc_q)]);
		nsum = sum_q + prod_q;

		remx = {rem_q, sqx_q[2*SW-1:2*SW-2]};
		trial = {2'b00, root_q, 2'b01};
		sq_ge = remx >= trial;

		nm = imusa_pkg::umag(ires_q[3'(c_q)]);
		um = (|drsp.quo[NW-1:31] || (drsp.quo[30] && |drsp.quo[29:0]))
			? 31'h4000_0000 : drsp.quo[30:0];
		unit_new = ires_q[3'(c_q)][SW-1] ? -SW'(um) : SW'(um);

		out_free = !out_valid_q || result_ready;
	end

	assign pop = (st_q == imusa_pkg::B_IDLE) && !empty;
	assign dreq = '{start: dstart_q, num: dnum_q, den: dden_q};
	assign result_valid = out_valid_q;
	assign result = out_q;

	always_comb begin
		st_d = st_q;
		unique case (st_q)
			imusa_pkg::B_IDLE:  if (!empty) st_d = imusa_pkg::B_SETUP;
			imusa_pkg::B_SETUP: begin
				if (!skip) st_d = imusa_pkg::B_MUL;
				else if (k_q == 3'd5) st_d = imusa_pkg::B_SQ;
			end
			imusa_pkg::B_MUL:   if (mcnt_q == 6'(TW - 1)) st_d = imusa_pkg::B_IDIV;
			imusa_pkg::B_IDIV: begin
				if (drsp.done) st_d = (k_q == 3'd5) ? imusa_pkg::B_SQ : imusa_pkg::B_SETUP;
			end
			imusa_pkg::B_SQ: begin
				if (sc_q == 2'd3) st_d = (nsum == '0) ? imusa_pkg::B_DONE : imusa_pkg::B_SQRT;
			end
			imusa_pkg::B_SQRT:  if (qcnt_q == 5'(SW - 1)) st_d = imusa_pkg::B_NSET;
			imusa_pkg::B_NSET:  st_d = imusa_pkg::B_NDIV;
			imusa_pkg::B_NDIV: begin
				if (drsp.done) st_d = (c_q == 2'd2) ? imusa_pkg::B_DONE : imusa_pkg::B_NSET;
			end
			imusa_pkg::B_DONE:  if (out_free) st_d = imusa_pkg::B_IDLE;
			default:            st_d = imusa_pkg::B_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= imusa_pkg::B_IDLE;
		end else begin
			st_q <= st_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			dstart_q    <= 1'b0;
		end else begin
			dstart_q <= 1'b0;
			if (st_q == imusa_pkg::B_DONE && out_free) out_valid_q <= 1'b1;
			else if (result_ready) out_valid_q <= 1'b0;
			if ((st_q == imusa_pkg::B_MUL && mcnt_q == 6'(TW - 1))
					|| st_q == imusa_pkg::B_NSET)
				dstart_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		case (st_q)
			imusa_pkg::B_IDLE: begin
				job_q <= job;
				k_q   <= '0;
			end
			imusa_pkg::B_SETUP: begin
				y1_q   <= y1;
				neg_q  <= neg;
				span_q <= span;
				el_q   <= el;
				mc_q   <= NW'(my);
				acc_q  <= '0;
				mcnt_q <= '0;
				sc_q   <= '0;
				sum_q  <= '0;
				if (skip) begin
					ires_q[k_q] <= y1;
					k_q <= k_q + 1'b1;
				end
			end
			imusa_pkg::B_MUL: begin
				if (el_q[0]) acc_q <= acc_q + mc_q;
				mc_q   <= {mc_q[NW-2:0], 1'b0};
				el_q   <= {1'b0, el_q[TW-1:1]};
				mcnt_q <= mcnt_q + 1'b1;
				dnum_q <= el_q[0] ? acc_q + mc_q : acc_q;
				dden_q <= DW'(span_q);
			end
			imusa_pkg::B_IDIV: begin
				if (drsp.done) begin
					ires_q[k_q] <= ires_new;
					k_q <= k_q + 1'b1;
				end
			end
			imusa_pkg::B_SQ: begin
				prod_q <= sqm * sqm;
				if (sc_q != 2'd0) sum_q <= nsum;
				sc_q   <= sc_q + 1'b1;
				sqx_q  <= nsum;
				root_q <= '0;
				rem_q  <= '0;
				qcnt_q <= '0;
				c_q    <= '0;
				// zero vector: unit vector is all zero
				for (int i = 0; i < 3; i++) unit_q[i] <= '0;
			end
			imusa_pkg::B_SQRT: begin
				rem_q  <= sq_ge ? (SW+2)'(remx - trial) : remx[SW+1:0];
				root_q <= {root_q[SW-2:0], sq_ge};
				sqx_q  <= {sqx_q[2*SW-3:0], 2'b00};
				qcnt_q <= qcnt_q + 1'b1;
			end
			imusa_pkg::B_NSET: begin
				dnum_q <= NW'({nm, 30'd0});
				dden_q <= DW'(root_q);
			end
			imusa_pkg::B_NDIV: begin
				if (drsp.done) begin
					unit_q[c_q] <= unit_new;
					c_q <= c_q + 1'b1;
				end
			end
			imusa_pkg::B_DONE: begin
				if (out_free) begin
					out_q.acc_unit_x   <= unit_q[0];
					out_q.acc_unit_y   <= unit_q[1];
					out_q.acc_unit_z   <= unit_q[2];
					out_q.mag_interp_x <= ires_q[3];
					out_q.mag_interp_y <= ires_q[4];
					out_q.mag_interp_z <= ires_q[5];
					out_q.rate_x       <= job_q.gyro[0];
					out_q.rate_y       <= job_q.gyro[1];
					out_q.rate_z       <= job_q.gyro[2];
					out_q.align_time   <= job_q.gyro_time;
				end
			end
			default: ;
		endcase
	end

endmodule

@@ src/imu_sample_aligner_interpolator_top.sv @@
`timescale 1ns / 1ps
// Sample intake is registered; an aligning transaction is queued for the math engine.
// Engine steps: 6 component interpolations (setup, then where needed a 48-step shift-add
// multiply and a divide with start and done), sum of squares, then unless the sum is zero
// a square root and 3 normalizing divides. The shared serial divider sets the pace.
// Reset clears all slots, flags and the queue.
module imu_sample_aligner_interpolator_top #(
	parameter int QUEUE_DEPTH = 2
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                sample_valid,
	output logic                sample_ready,
	input  imusa_pkg::sample_t  sample,
	output logic                result_valid,
	input  logic                result_ready,
	output imusa_pkg::result_t  result
);

	imusa_pkg::job_t push_job, pop_job;
	logic push, pop, full, empty;
	imusa_pkg::div_req_t dreq;
	imusa_pkg::div_rsp_t drsp;

	imusa_front u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.sample_valid (sample_valid),
		.sample_ready (sample_ready),
		.sample       (sample),
		.full         (full),
		.push         (push),
		.job          (push_job)
	);

	imusa_fifo #(.DEPTH(QUEUE_DEPTH)) u_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.wdata  (push_job),
		.pop    (pop),
		.rdata  (pop_job),
		.full   (full),
		.empty  (empty)
	);

	imusa_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (dreq),
		.rsp    (drsp)
	);

	imusa_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.empty        (empty),
		.job          (pop_job),
		.pop          (pop),
		.dreq         (dreq),
		.drsp         (drsp),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.result       (result)
	);

endmodule

@@ dv/imu_sample_aligner_interpolator_top_tb.sv @@
`timescale 1ns / 1ps
module imu_sample_aligner_interpolator_top_tb;

	localparam logic [1:0] SENS_SPARE = 2'd3;
	localparam longint SMAX = 64'sd2147483647;
	localparam longint SMIN = -64'sd2147483648;
	localparam logic [63:0] UNIT = 64'd1 << 30;
	localparam int CYCLE_LIMIT = 3000000;
	localparam int DRAIN_CYCLES = 1500;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic sample_valid = 1'b0;
	logic sample_ready;
	imusa_pkg::sample_t sample = '0;
	logic result_valid;
	logic result_ready = 1'b0;
	imusa_pkg::result_t result;

	imu_sample_aligner_interpolator_top dut (
		.clk(clk), .arst_n(arst_n),
		.sample_valid(sample_valid), .sample_ready(sample_ready), .sample(sample),
		.result_valid(result_valid), .result_ready(result_ready), .result(result)
	);

	initial begin
		forever #4 clk = ~clk;
	end

	// aligner state mirror
	longint acc_prev[3], acc_next[3], mag_prev[3], mag_next[3], gyro_v[3];
	logic [47:0] acc_prev_t, acc_next_t, mag_prev_t, mag_next_t, gyro_t;
	bit gyro_held, acc_held, mag_held;

	imusa_pkg::result_t aligned_q[$];
	int errors = 0;
	int cycles = 0;
	int send_idle_pct = 0;
	int recv_stall_pct = 0;

	task automatic report(string what, logic [63:0] got, logic [63:0] want);
		errors++;
		$display("[%0t] %s: got %h expected %h", $realtime, what, got, want);
	endtask

	function automatic longint lerp_axis(longint y1, longint y2, logic [47:0] t1,
			logic [47:0] t2, logic [47:0] t3);
		longint dy, res;
		logic [63:0] my, span, el;
		logic [127:0] prod, q, r;
		bit neg;
		dy = y2 - y1;
		neg = dy < 0;
		my = neg ? -dy : dy;
		if (t1 == t2 || my == 0 || t3 == t1)
			return y1;
		if (t2 > t1) span = t2 - t1; else begin span = t1 - t2; neg = !neg; end
		if (t3 > t1) el = t3 - t1; else begin el = t1 - t3; neg = !neg; end
		prod = 128'(my) * 128'(el);
		q = prod / 128'(span);
		r = prod % 128'(span);
		if (r >= 128'(span) - r)
			q++;
		if (q > 128'(64'd1 << 32))
			return neg ? SMIN : SMAX;
		res = neg ? y1 - longint'(q[63:0]) : y1 + longint'(q[63:0]);
		if (res > SMAX) res = SMAX;
		if (res < SMIN) res = SMIN;
		return res;
	endfunction

	function automatic logic [63:0] floor_sqrt(logic [127:0] s);
		logic [63:0] root, c;
		root = '0;
		for (int i = 63; i >= 0; i--) begin
			c = root | (64'd1 << i);
			if (128'(c) * 128'(c) <= s)
				root = c;
		end
		return root;
	endfunction

	function automatic imusa_pkg::smp_t unit_axis(longint v, logic [63:0] len);
		logic [63:0] m;
		logic [127:0] q, r, num;
		m = v < 0 ? -v : v;
		num = 128'(m) * 128'(UNIT);
		q = num / 128'(len);
		r = num % 128'(len);
		if (r >= 128'(len) - r)
			q++;
		if (q > 128'(UNIT))
			q = 128'(UNIT);
		return v < 0 ? imusa_pkg::smp_t'(-longint'(q[63:0])) : imusa_pkg::smp_t'(q[63:0]);
	endfunction

	// update the mirror with one sample; return 1 when it aligns
	function automatic bit align_sample(imusa_pkg::sample_t s, output imusa_pkg::result_t r);
		longint v[3], a[3];
		logic [127:0] sumsq;
		logic [63:0] m, len;
		v[0] = longint'(s.sample_x);
		v[1] = longint'(s.sample_y);
		v[2] = longint'(s.sample_z);
		r = '0;
		if (!gyro_held) begin
			if (s.sensor_type == imusa_pkg::SENS_ACC) begin
				acc_prev = v; acc_prev_t = s.timestamp;
			end else if (s.sensor_type == imusa_pkg::SENS_MAG) begin
				mag_prev = v; mag_prev_t = s.timestamp;
			end else begin
				gyro_v = v; gyro_t = s.timestamp; gyro_held = 1;
			end
		end else begin
			if (s.sensor_type == imusa_pkg::SENS_ACC) begin
				acc_next = v; acc_next_t = s.timestamp; acc_held = 1;
			end else if (s.sensor_type == imusa_pkg::SENS_MAG) begin
				mag_next = v; mag_next_t = s.timestamp; mag_held = 1;
			end else begin
				gyro_v = v; gyro_t = s.timestamp;
				if (acc_held) begin acc_prev = acc_next; acc_prev_t = acc_next_t; end
				if (mag_held) begin mag_prev = mag_next; mag_prev_t = mag_next_t; end
				acc_held = 0;
				mag_held = 0;
			end
		end
		if (!(acc_held && mag_held))
			return 0;
		sumsq = '0;
		for (int i = 0; i < 3; i++) begin
			a[i] = lerp_axis(acc_prev[i], acc_next[i], acc_prev_t, acc_next_t, gyro_t);
			m = a[i] < 0 ? -a[i] : a[i];
			sumsq += 128'(m) * 128'(m);
		end
		len = floor_sqrt(sumsq);
		if (sumsq != 0) begin
			r.acc_unit_x = unit_axis(a[0], len);
			r.acc_unit_y = unit_axis(a[1], len);
			r.acc_unit_z = unit_axis(a[2], len);
		end
		r.mag_interp_x = imusa_pkg::smp_t'(lerp_axis(mag_prev[0], mag_next[0],
			mag_prev_t, mag_next_t, gyro_t));
		r.mag_interp_y = imusa_pkg::smp_t'(lerp_axis(mag_prev[1], mag_next[1],
			mag_prev_t, mag_next_t, gyro_t));
		r.mag_interp_z = imusa_pkg::smp_t'(lerp_axis(mag_prev[2], mag_next[2],
			mag_prev_t, mag_next_t, gyro_t));
		r.rate_x = imusa_pkg::smp_t'(gyro_v[0]);
		r.rate_y = imusa_pkg::smp_t'(gyro_v[1]);
		r.rate_z = imusa_pkg::smp_t'(gyro_v[2]);
		r.align_time = gyro_t;
		gyro_held = 0; acc_held = 0; mag_held = 0;
		acc_prev = acc_next; acc_prev_t = acc_next_t;
		mag_prev = mag_next; mag_prev_t = mag_next_t;
		return 1;
	endfunction

	function automatic imusa_pkg::sample_t mk(logic [1:0] kind, logic [31:0] x,
			logic [31:0] y, logic [31:0] z, logic [47:0] ts);
		imusa_pkg::sample_t s;
		s.sensor_type = kind;
		s.sample_x = x;
		s.sample_y = y;
		s.sample_z = z;
		s.timestamp = ts;
		return s;
	endfunction

	// present one transaction and hold it until accepted; valid stays high afterward
	task automatic send(imusa_pkg::sample_t s, bit has_typed, imusa_pkg::result_t typed);
		imusa_pkg::result_t r;
		if ($urandom_range(99) < send_idle_pct) begin
			sample_valid <= 1'b0;
			do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
		end
		sample_valid <= 1'b1;
		sample <= s;
		do @(posedge clk); while (!sample_ready);
		if (align_sample(s, r))
			aligned_q.insert(aligned_q.size(), has_typed ? typed : r);
	endtask

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("SCOREBOARD MISMATCH");
			$finish;
		end
	end

	always @(posedge clk) begin
		imusa_pkg::result_t want;
		if (arst_n) begin
			if (result_valid && result_ready) begin
				if (aligned_q.size() == 0) begin
					report("unexpected result", result.align_time, '0);
				end else begin
					want = aligned_q.pop_front();
					if (result.acc_unit_x !== want.acc_unit_x)
						report("acc_unit_x", result.acc_unit_x, want.acc_unit_x);
					if (result.acc_unit_y !== want.acc_unit_y)
						report("acc_unit_y", result.acc_unit_y, want.acc_unit_y);
					if (result.acc_unit_z !== want.acc_unit_z)
						report("acc_unit_z", result.acc_unit_z, want.acc_unit_z);
					if (result.mag_interp_x !== want.mag_interp_x)
						report("mag_interp_x", result.mag_interp_x, want.mag_interp_x);
					if (result.mag_interp_y !== want.mag_interp_y)
						report("mag_interp_y", result.mag_interp_y, want.mag_interp_y);
					if (result.mag_interp_z !== want.mag_interp_z)
						report("mag_interp_z", result.mag_interp_z, want.mag_interp_z);
					if (result.rate_x !== want.rate_x)
						report("rate_x", result.rate_x, want.rate_x);
					if (result.rate_y !== want.rate_y)
						report("rate_y", result.rate_y, want.rate_y);
					if (result.rate_z !== want.rate_z)
						report("rate_z", result.rate_z, want.rate_z);
					if (result.align_time !== want.align_time)
						report("align_time", result.align_time, want.align_time);
				end
			end
			result_ready <= ($urandom_range(99) >= recv_stall_pct);
		end
	end

	function automatic logic [31:0] rand_axis();
		case ($urandom_range(3))
			0: return $urandom();
			1: return 32'($signed($urandom_range(65536 * 40)) - 65536 * 20);
			2: return $urandom_range(1) ? 32'h7fffffff : 32'h80000000;
			default: return 32'($signed($urandom_range(200)) - 100);
		endcase
	endfunction

	logic [47:0] clock_ticks = 48'd1000;

	function automatic logic [47:0] next_tick();
		if ($urandom_range(19) == 0)
			return 48'({$urandom(), $urandom()});
		clock_ticks += $urandom_range(1) ? $urandom_range(500) : $urandom_range(3);
		return clock_ticks;
	endfunction

	task automatic send_rand(logic [1:0] kind);
		send(mk(kind, rand_axis(), rand_axis(), rand_axis(), next_tick()), 0, '0);
	endtask

	imusa_pkg::sample_t steer[12];
	bit steer_typed[12];
	imusa_pkg::result_t steer_want[12];
	int sent;
	int phase_idle[4] = '{0, 83, 0, 30};
	int phase_stall[4] = '{0, 0, 83, 30};

	initial begin
		imusa_pkg::result_t first;
		first = '0;
		first.mag_interp_x = 32'h0001_0000;
		first.mag_interp_y = 32'h0001_0000;
		first.mag_interp_z = 32'hffff_0000;
		first.rate_x = 32'd1;
		first.rate_y = 32'd2;
		first.rate_z = 32'd3;
		first.align_time = 48'd100;

		// after reset: zero accel vector, mag halfway between zero and its next sample
		steer[0] = mk(imusa_pkg::SENS_GYRO, 1, 2, 3, 100);
		steer[1] = mk(imusa_pkg::SENS_ACC, 0, 0, 0, 200);
		steer[2] = mk(imusa_pkg::SENS_MAG, 32'h2_0000, 32'h2_0000, 32'hfffe_0000, 200);
		// extremes, spare sensor code as gyro, time running backward
		steer[3] = mk(imusa_pkg::SENS_ACC, 32'h7fffffff, 32'h80000000, 0, 300);
		steer[4] = mk(imusa_pkg::SENS_MAG, 32'h80000000, 32'h7fffffff, 1, 300);
		steer[5] = mk(SENS_SPARE, 32'hffffffff, 32'h80000000, 32'h7fffffff,
			48'hffff_ffff_ffff);
		steer[6] = mk(imusa_pkg::SENS_ACC, 32'h80000000, 32'h80000000, 32'h80000000, 0);
		// second gyro shifts the filled next slot
		steer[7] = mk(imusa_pkg::SENS_GYRO, 5, 6, 7, 50);
		// zero time span on accel, saturating mag
		steer[8] = mk(imusa_pkg::SENS_ACC, 32'h0001_0000, 0, 0, 0);
		steer[9] = mk(imusa_pkg::SENS_MAG, 32'h7fffffff, 32'h80000000, 0, 48'd51);
		steer[10] = mk(imusa_pkg::SENS_GYRO, 9, 9, 9, 48'd10);
		steer[11] = mk(imusa_pkg::SENS_MAG, 32'h80000000, 32'h7fffffff, 32'h40000000,
			48'd11);
		steer_typed = '{default: 0};
		steer_typed[2] = 1;
		steer_want[2] = first;

		acc_prev = '{0, 0, 0}; acc_next = '{0, 0, 0}; mag_prev = '{0, 0, 0};
		mag_next = '{0, 0, 0}; gyro_v = '{0, 0, 0};
		acc_prev_t = '0; acc_next_t = '0; mag_prev_t = '0; mag_next_t = '0; gyro_t = '0;
		gyro_held = 0; acc_held = 0; mag_held = 0;

		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (steer[i])
			send(steer[i], steer_typed[i], steer_want[i]);
		send(mk(imusa_pkg::SENS_ACC, 32'h0000_8000, 32'hffff_8000, 32'h0001_0000, 48'd20),
			0, '0);

		sent = 13;
		for (int p = 0; p < 4; p++) begin
			send_idle_pct = phase_idle[p];
			recv_stall_pct = phase_stall[p];
			while (sent < 13 + (p + 1) * 210) begin
				if ($urandom_range(99) < 80) begin
					// well-formed: optional previous samples, gyro, then both next samples
					repeat ($urandom_range(2)) begin
						send_rand($urandom_range(1) ? imusa_pkg::SENS_ACC : imusa_pkg::SENS_MAG);
						sent++;
					end
					send_rand($urandom_range(7) == 0 ? SENS_SPARE : imusa_pkg::SENS_GYRO);
					if ($urandom_range(1)) begin
						send_rand(imusa_pkg::SENS_ACC); send_rand(imusa_pkg::SENS_MAG);
					end else begin
						send_rand(imusa_pkg::SENS_MAG); send_rand(imusa_pkg::SENS_ACC);
					end
					sent += 3;
				end else begin
					send_rand(2'($urandom_range(3)));
					sent++;
				end
			end
		end
		sample_valid <= 1'b0;

		while (aligned_q.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (errors == 0) begin
			$display("SCOREBOARD CLEAN");
		end else begin
			$display("SCOREBOARD MISMATCH");
		end
		$finish;
	end

endmodule
